@@ design/svu_pkg.sv @@
// ----------------------------------------------------------------------------
// svu_pkg
// shared types, constants and helpers for the softmax vector unit
// ----------------------------------------------------------------------------
package svu_pkg;

    localparam int MAX_LEN   = 32;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int SUM_W     = 22;
    localparam int QDEPTH    = 2;
    localparam logic [8:0] LOG2E_Q8 = 9'd369;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [15:0] probability;
        logic [4:0]  element_index;
        logic        last_result;
    } t_out_item;

    // one entry of the queue between front and back
    typedef struct packed {
        logic               store;
        logic               last;
        logic signed [15:0] logit;
    } t_cmd;

    // 2^(-k/16) in Q1.15
    function automatic logic [15:0] pow2_tab(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:  v = 16'd32768;
            5'd1:  v = 16'd31379;
            5'd2:  v = 16'd30048;
            5'd3:  v = 16'd28774;
            5'd4:  v = 16'd27554;
            5'd5:  v = 16'd26386;
            5'd6:  v = 16'd25268;
            5'd7:  v = 16'd24196;
            5'd8:  v = 16'd23170;
            5'd9:  v = 16'd22188;
            5'd10: v = 16'd21247;
            5'd11: v = 16'd20347;
            5'd12: v = 16'd19484;
            5'd13: v = 16'd18658;
            5'd14: v = 16'd17867;
            5'd15: v = 16'd17109;
            default: v = 16'd16384;
        endcase
        return v;
    endfunction

endpackage

@@ design/svu_stream_if.sv @@
// ----------------------------------------------------------------------------
// svu_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface svu_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/softmax_vector_unit.sv @@
// ----------------------------------------------------------------------------
// softmax_vector_unit
// fixed-point softmax over a vector of logits, maximum subtracted first
// ----------------------------------------------------------------------------
// usage
//   s_in carries one Q8.8 logit per transfer with a last flag; m_out returns
//   one Q0.16 probability per stored element, in input order, with its index
//   and a last flag on the final one. Up to 32 elements are stored; extra
//   elements are dropped, a dropped last element still closes the vector.
// timing
//   loading takes one element per cycle through a two-entry command queue
//   while the sequencer is loading. the exp pass runs each element through
//   ram read, multiply, table interpolation and shift, write and sum. the
//   divide pass runs each element through ram read, start, the bit-serial
//   restoring divider (39 steps), done and the output transfer. elements
//   of the next vector queue up while a vector is in its passes.
// reset
//   synchronous, active low; clears the queue, count, maximum and sum.
// back pressure
//   a result waits in the output register while m_out is stalled; the
//   sequencer holds until it is taken.
// ----------------------------------------------------------------------------
module softmax_vector_unit
    import svu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    svu_stream_if.sink   s_in,
    svu_stream_if.source m_out
);
    t_cmd      cmd;
    logic      cmd_valid, cmd_pop;
    t_out_item out_item;

    svu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_in.valid),
        .o_ready    (s_in.ready),
        .i_item     (t_in_item'(s_in.data)),
        .o_cmd_valid(cmd_valid),
        .i_cmd_pop  (cmd_pop),
        .o_cmd      (cmd)
    );

    svu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_valid    (m_out.valid),
        .i_ready    (m_out.ready),
        .o_item     (out_item)
    );

    assign m_out.data = out_item;

    // a pop never happens on an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd_pop |-> cmd_valid)
        else $error("command pop on empty queue");

    // a stalled result holds its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(m_out.data))
        else $error("result changed while stalled");
endmodule

@@ design/svu_ram.sv @@
// ----------------------------------------------------------------------------
// svu_ram
// generic single-port-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module svu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/svu_front.sv @@
// ----------------------------------------------------------------------------
// svu_front
// accepts logits, classifies them as stored or dropped, queues commands
// ----------------------------------------------------------------------------
module svu_front
    import svu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_pop,
    output t_cmd     o_cmd
);
    localparam int QP_W = $clog2(QDEPTH);

    t_cmd             r_q [QDEPTH];
    logic [QP_W-1:0]  r_wp, r_rp;
    logic [QP_W:0]    r_fill;
    logic [CNT_W-1:0] r_cnt;
    logic             push;

    assign o_ready     = (r_fill != QDEPTH[QP_W:0]);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rp];

    // queue and element count of the vector being taken in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_q[r_wp].store <= (r_cnt != MAX_LEN[CNT_W-1:0]);
                r_q[r_wp].last  <= i_item.last_item;
                r_q[r_wp].logit <= i_item.logit;
                r_wp            <= r_wp + 1'b1;
                if (i_item.last_item) begin
                    r_cnt <= '0;
                end else if (r_cnt != MAX_LEN[CNT_W-1:0]) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fill <= r_fill + {{QP_W{1'b0}}, push} - {{QP_W{1'b0}}, i_cmd_pop};
        end
    end
endmodule

@@ design/svu_divider.sv @@
// ----------------------------------------------------------------------------
// svu_divider
// restoring divider, one quotient bit per cycle, 17-bit quotient
// ----------------------------------------------------------------------------
module svu_divider
    import svu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [38:0]      i_num,
    input  logic [SUM_W-1:0] i_den,
    output logic             o_done,
    output logic [15:0]      o_quot
);
    logic [38:0]      r_num;
    logic [SUM_W:0]   r_rem;
    logic [16:0]      r_q;
    logic [5:0]       r_step;
    logic             r_busy;
    logic [SUM_W:0]   trial;
    logic [SUM_W+1:0] diff;

    // remainder stays below the divisor, so its low 22 bits carry it;
    // the quotient fits in 17 bits, so only those bits are kept
    assign trial = {r_rem[SUM_W-1:0], r_num[38]};
    assign diff  = {1'b0, trial} - {2'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_rem  <= '0;
                r_q    <= '0;
                r_step <= 6'd39;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[37:0], 1'b0};
                if (!diff[SUM_W+1]) begin
                    r_rem <= diff[SUM_W:0];
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // saturate at the top code
    assign o_quot = r_q[16] ? 16'hFFFF : r_q[15:0];
endmodule

@@ design/svu_back.sv @@
// ----------------------------------------------------------------------------
// svu_back
// stores logits, then runs the exp pass and the divide pass per vector
// ----------------------------------------------------------------------------
module svu_back
    import svu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    typedef enum logic [2:0] {
        S_LOAD, S_EXP_RD, S_EXP_MUL, S_EXP_INT, S_EXP_WR, S_DIV_RD, S_DIV_RUN, S_OUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_i;
    logic signed [15:0] r_max;
    logic [SUM_W-1:0]   r_sum;
    logic [24:0]        r_t;
    logic [15:0]        r_e;
    logic               r_div_go;

    logic               lg_we, ex_we;
    logic [IDX_W-1:0]   lg_waddr;
    logic [15:0]        lg_rdata, ex_rdata, ex_wdata;
    logic [16:0]        d;
    logic [4:0]         tidx;
    logic [11:0]        tr;
    logic [15:0]        ta, tb;
    logic [28:0]        interp;
    logic               div_done;
    logic [15:0]        quot;
    logic [15:0]        e_val;
    logic               last_i;

    assign lg_waddr = r_cnt[IDX_W-1:0];
    assign lg_we    = (r_state == S_LOAD) && i_cmd_valid && i_cmd.store;
    assign o_cmd_pop = (r_state == S_LOAD) && i_cmd_valid;
    assign ex_we    = (r_state == S_EXP_WR);
    assign ex_wdata = r_e;

    svu_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_logit_ram (
        .i_clk  (i_clk),
        .i_we   (lg_we),
        .i_waddr(lg_waddr),
        .i_wdata(i_cmd.logit),
        .i_raddr(r_i),
        .o_rdata(lg_rdata)
    );

    svu_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_exp_ram (
        .i_clk  (i_clk),
        .i_we   (ex_we),
        .i_waddr(r_i),
        .i_wdata(ex_wdata),
        .i_raddr(r_i),
        .o_rdata(ex_rdata)
    );

    // distance from the maximum, then the log2(e) product
    assign d = 17'($signed({r_max[15], r_max}) - $signed({lg_rdata[15], lg_rdata}));

    // fraction of the power of two through the interpolated table
    assign tidx   = {1'b0, r_t[15:12]};
    assign tr     = r_t[11:0];
    assign ta     = pow2_tab(tidx);
    assign tb     = pow2_tab(tidx + 5'd1);
    assign interp = 29'(ta - tb) * 29'(tr) + 29'd2048;

    assign last_i = ({1'b0, r_i} + 1'b1) == r_cnt;

    svu_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  ({7'd0, ex_rdata, 16'd0} + {17'd0, r_sum >> 1}),
        .i_den  (r_sum),
        .o_done (div_done),
        .o_quot (quot)
    );
    assign e_val = quot;

    // sequencer: load, exp pass, divide pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_i      <= '0;
            r_max    <= 16'sh8000;
            r_sum    <= '0;
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.store) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (i_cmd.logit > r_max) begin
                                r_max <= i_cmd.logit;
                            end
                        end
                        if (i_cmd.last) begin
                            r_i     <= '0;
                            r_sum   <= '0;
                            r_state <= S_EXP_RD;
                        end
                    end
                end
                S_EXP_RD: begin
                    r_state <= S_EXP_MUL;
                end
                S_EXP_MUL: begin
                    r_t     <= 25'(d) * 25'(LOG2E_Q8);
                    r_state <= S_EXP_INT;
                end
                S_EXP_INT: begin
                    r_state <= S_EXP_WR;
                    r_e     <= '0;
                end
                S_EXP_WR: begin
                    // handled below via r_e computed from the table
                    r_sum <= r_sum + SUM_W'(r_e);
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_DIV_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EXP_RD;
                    end
                end
                S_DIV_RD: begin
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    if (div_done) begin
                        o_valid              <= 1'b1;
                        o_item.probability   <= e_val;
                        o_item.element_index <= 5'(r_i);
                        o_item.last_result   <= last_i;
                        r_state              <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (last_i) begin
                            r_cnt   <= '0;
                            r_max   <= 16'sh8000;
                            r_sum   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DIV_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            // integer part of the exponent: right shift, zero beyond 15
            if (r_state == S_EXP_INT) begin
                r_e <= '0;
            end
            if (r_state == S_EXP_INT && r_t[24:20] == 5'd0) begin
                r_e <= (ta - interp[27:12]) >> r_t[19:16];
            end
        end
    end
endmodule
